[design/hvd_pkg.sv]
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared widths, fixed-point constants and defaults for the haversine core.
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 20;

    // Port widths.
    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int DIST_W = 23;

    // Internal Q30 widths.
    localparam int COS_W  = 32;    // signed cosine, [-2^30, 2^30]
    localparam int HAV_W  = 31;    // haversine or nonnegative cosine, [0, 2^30]
    localparam int ARG_W  = 30;    // asin(sqrt()) argument, at most 2^29
    localparam int ANG_W  = 31;    // angle in radians, Q30

    localparam int COS_TERMS  = 9;
    localparam int ASIN_TERMS = 40;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_Q30    = 31'h2000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] DEG2RAD_Q36 = 31'd1199381129;
    localparam logic [21:0] DIST_SCALE  = 22'd3261952;     // 2 * 6371 * 256
    localparam logic [22:0] DIST_MAX    = 23'd5124096;

endpackage

[design/hvd_cos.sv]
// ----------------------------------------------------------------------------
// hvd_cos
// Pipelined cosine of a nonnegative degree angle, signed Q30 result.
// ----------------------------------------------------------------------------
module hvd_cos
    import hvd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [ANGLE_FRAC_BITS+8:0]     deg,
    output logic                           out_valid,
    output logic signed [COS_W-1:0]        cos_val
);

    localparam int DW = ANGLE_FRAC_BITS + 9;
    localparam int FW = ANGLE_FRAC_BITS + 7;
    localparam logic [DW-1:0] D90  = DW'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic [DW-1:0] D180 = DW'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic [DW-1:0] D360 = DW'(64'd360 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic [31:0]        x2;
        logic signed [33:0] acc;
        logic               neg;
    } cos_carry_t;

    // Range reduction: fold into [0, 180] and then into [0, 90].
    logic [DW-1:0] f1_deg_reg, f1_deg_next, deg_c;
    logic          f1_valid_reg;
    logic [FW-1:0] f2_deg_reg, f2_deg_next;
    logic          f2_neg_reg, f2_neg_next, f2_valid_reg;
    logic [30:0]   f3_x_reg;
    logic [63:0]   f3_prod;
    logic          f3_neg_reg, f3_valid_reg;
    logic [63:0]   f4_prod;

    always_comb
    begin
        deg_c       = (deg > D360) ? D360 : deg;
        f1_deg_next = (deg_c > D180) ? D360 - deg_c : deg_c;
        f2_neg_next = (f1_deg_reg > D90);
        f2_deg_next = f2_neg_next ? FW'(D180 - f1_deg_reg) : FW'(f1_deg_reg);
    end

    assign f3_prod = 64'(f2_deg_reg) * 64'(DEG2RAD_Q36);
    assign f4_prod = 64'(f3_x_reg) * 64'(f3_x_reg);

    // Series state: c_* is the running term and partial sum after each term.
    logic [31:0]  c_term_reg  [0:COS_TERMS];
    cos_carry_t   c_carry_reg [0:COS_TERMS];
    logic         c_valid_reg [0:COS_TERMS];
    logic [31:0]  a_n_reg     [1:COS_TERMS];
    cos_carry_t   a_carry_reg [1:COS_TERMS];
    logic         a_valid_reg [1:COS_TERMS];
    logic [31:0]  b_q0_reg    [1:COS_TERMS];
    logic [31:0]  b_n_reg     [1:COS_TERMS];
    cos_carry_t   b_carry_reg [1:COS_TERMS];
    logic         b_valid_reg [1:COS_TERMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg   <= 1'b0;
            f2_valid_reg   <= 1'b0;
            f3_valid_reg   <= 1'b0;
            c_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg   <= in_valid;
            f2_valid_reg   <= f1_valid_reg;
            f3_valid_reg   <= f2_valid_reg;
            c_valid_reg[0] <= f3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_deg_reg           <= f1_deg_next;
            f2_deg_reg           <= f2_deg_next;
            f2_neg_reg           <= f2_neg_next;
            f3_x_reg             <= 31'(f3_prod >> (ANGLE_FRAC_BITS + 6));
            f3_neg_reg           <= f2_neg_reg;
            c_term_reg[0]        <= 32'(ONE_Q30);
            c_carry_reg[0].x2    <= 32'(f4_prod >> 30);
            c_carry_reg[0].acc   <= 34'(ONE_Q30);
            c_carry_reg[0].neg   <= f3_neg_reg;
        end
    end

    // Each term: multiply by x^2, divide by (2k-1)(2k) through a reciprocal
    // with a one-step correction, then add or subtract.
    genvar k;
    generate
        for (k = 1; k <= COS_TERMS; k++)
        begin : g_term
            localparam int unsigned DivK   = (2 * k - 1) * (2 * k);
            localparam logic [31:0] RecipK = 32'((64'd1 << 32) / DivK);

            logic [63:0] a_prod, b_prod, c_prod;
            logic [31:0] c_rem, c_q;
            cos_carry_t  c_carry_next;

            assign a_prod = 64'(c_term_reg[k-1]) * 64'(c_carry_reg[k-1].x2);
            assign b_prod = 64'(a_n_reg[k]) * 64'(RecipK);
            assign c_prod = 64'(b_q0_reg[k]) * 64'(DivK);

            always_comb
            begin
                c_rem        = b_n_reg[k] - c_prod[31:0];
                c_q          = (c_rem >= 32'(DivK)) ? b_q0_reg[k] + 32'd1 : b_q0_reg[k];
                c_carry_next = b_carry_reg[k];
                if (k % 2 == 1)
                    c_carry_next.acc = b_carry_reg[k].acc - signed'(34'(c_q));
                else
                    c_carry_next.acc = b_carry_reg[k].acc + signed'(34'(c_q));
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    a_valid_reg[k] <= 1'b0;
                    b_valid_reg[k] <= 1'b0;
                    c_valid_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    a_valid_reg[k] <= c_valid_reg[k-1];
                    b_valid_reg[k] <= a_valid_reg[k];
                    c_valid_reg[k] <= b_valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_n_reg[k]     <= a_prod[61:30];
                    a_carry_reg[k] <= c_carry_reg[k-1];
                    b_q0_reg[k]    <= b_prod[63:32];
                    b_n_reg[k]     <= a_n_reg[k];
                    b_carry_reg[k] <= a_carry_reg[k];
                    c_term_reg[k]  <= c_q;
                    c_carry_reg[k] <= c_carry_next;
                end
            end
        end
    endgenerate

    // Clamp the sum to [0, 1] and restore the sign from the quadrant fold.
    logic signed [33:0]      fin_acc;
    logic [30:0]             fin_mag;
    logic signed [COS_W-1:0] cos_next, cos_reg;
    logic                    cos_valid_reg;

    always_comb
    begin
        fin_acc = c_carry_reg[COS_TERMS].acc;
        if (fin_acc < 0)
            fin_mag = '0;
        else if (fin_acc > signed'(34'(ONE_Q30)))
            fin_mag = ONE_Q30;
        else
            fin_mag = fin_acc[30:0];
        cos_next = c_carry_reg[COS_TERMS].neg ? -signed'({1'b0, fin_mag})
                                              : signed'({1'b0, fin_mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cos_valid_reg <= 1'b0;
        else if (en)
            cos_valid_reg <= c_valid_reg[COS_TERMS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cos_reg <= cos_next;
    end

    assign out_valid = cos_valid_reg;
    assign cos_val   = cos_reg;

endmodule

[design/hvd_asin.sv]
// ----------------------------------------------------------------------------
// hvd_asin
// Pipelined asin(sqrt(b)) for b <= 1/2: digit-serial square root followed
// by one power-series term per group of five stages.
// ----------------------------------------------------------------------------
module hvd_asin
    import hvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [ARG_W-1:0]   arg,
    input  logic               arg_flag,
    output logic               out_valid,
    output logic [ANG_W-1:0]   angle,
    output logic               angle_flag
);

    localparam int SQ_STEPS = ARG_W;

    typedef struct packed {
        logic [ARG_W-1:0] b;
        logic [ARG_W-1:0] q;
        logic [ANG_W-1:0] sum;
        logic             flag;
    } ser_t;

    // Square root of b * 2^30, one result bit per stage.
    logic [31:0]      sq_rem_reg   [0:SQ_STEPS-1];
    logic [ARG_W-1:0] sq_root_reg  [0:SQ_STEPS-1];
    logic [ARG_W-1:0] sq_b_reg     [0:SQ_STEPS-1];
    logic             sq_flag_reg  [0:SQ_STEPS-1];
    logic             sq_valid_reg [0:SQ_STEPS-1];

    genvar i;
    generate
        for (i = 0; i < SQ_STEPS; i++)
        begin : g_sqrt
            logic [31:0]      rem_in, rem_next;
            logic [ARG_W-1:0] root_in, b_in, root_next;
            logic             flag_in, valid_in, ge;
            logic [1:0]       pair;
            logic [33:0]      rem_sh, trial;

            if (i == 0)
            begin : g_first
                assign rem_in   = '0;
                assign root_in  = '0;
                assign b_in     = arg;
                assign flag_in  = arg_flag;
                assign valid_in = in_valid;
            end
            else
            begin : g_next
                assign rem_in   = sq_rem_reg[i-1];
                assign root_in  = sq_root_reg[i-1];
                assign b_in     = sq_b_reg[i-1];
                assign flag_in  = sq_flag_reg[i-1];
                assign valid_in = sq_valid_reg[i-1];
            end

            // The low half of the radicand is all zero.
            if (i < ARG_W / 2)
            begin : g_pair
                assign pair = b_in[ARG_W-1-2*i -: 2];
            end
            else
            begin : g_zero
                assign pair = 2'b00;
            end

            always_comb
            begin
                rem_sh    = {rem_in, pair};
                trial     = {2'b00, root_in, 2'b01};
                ge        = (rem_sh >= trial);
                rem_next  = ge ? 32'(rem_sh - trial) : rem_sh[31:0];
                root_next = {root_in[ARG_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_valid_reg[i] <= 1'b0;
                else if (en)
                    sq_valid_reg[i] <= valid_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[i]  <= rem_next;
                    sq_root_reg[i] <= root_next;
                    sq_b_reg[i]    <= b_in;
                    sq_flag_reg[i] <= flag_in;
                end
            end
        end
    endgenerate

    ser_t ser_init;
    assign ser_init = '{b:    sq_b_reg[SQ_STEPS-1],
                        q:    sq_root_reg[SQ_STEPS-1],
                        sum:  {1'b0, sq_root_reg[SQ_STEPS-1]},
                        flag: sq_flag_reg[SQ_STEPS-1]};

    ser_t        s1_reg [1:ASIN_TERMS];
    ser_t        s2_reg [1:ASIN_TERMS];
    ser_t        s3_reg [1:ASIN_TERMS];
    ser_t        s4_reg [1:ASIN_TERMS];
    ser_t        s5_reg [1:ASIN_TERMS];
    logic [30:0] s2_p2_reg [1:ASIN_TERMS];
    logic [30:0] s2_q0_reg [1:ASIN_TERMS];
    logic [30:0] s4_q0_reg [1:ASIN_TERMS];
    logic        v1_reg [1:ASIN_TERMS];
    logic        v2_reg [1:ASIN_TERMS];
    logic        v3_reg [1:ASIN_TERMS];
    logic        v4_reg [1:ASIN_TERMS];
    logic        v5_reg [1:ASIN_TERMS];

    // Term n: q = floor(q*b) * (2n-1)/(2n), sum += q/(2n+1). The first
    // division is taken as q - ceil(q/(2n)); both use reciprocals.
    genvar n;
    generate
        for (n = 1; n <= ASIN_TERMS; n++)
        begin : g_series
            localparam int unsigned DivA = 2 * n;
            localparam int unsigned DivB = 2 * n + 1;
            localparam logic [30:0] RecA = 31'((64'd1 << 31) / DivA);
            localparam logic [30:0] RecB = 31'((64'd1 << 31) / DivB);

            ser_t        src, s1_next, s3_next, s5_next;
            logic        src_valid;
            logic [63:0] p1, p2m, p3, p4, p5;
            logic [30:0] p2_next, rem3, c3, rem5, d5;

            if (n == 1)
            begin : g_first
                assign src       = ser_init;
                assign src_valid = sq_valid_reg[SQ_STEPS-1];
            end
            else
            begin : g_next
                assign src       = s5_reg[n-1];
                assign src_valid = v5_reg[n-1];
            end

            assign p1      = 64'(src.q) * 64'(src.b);
            assign p2_next = 31'(s1_reg[n].q) + 31'(DivA - 1);
            assign p2m     = 64'(p2_next) * 64'(RecA);
            assign p3      = 64'(s2_q0_reg[n]) * 64'(DivA);
            assign p4      = 64'(s3_reg[n].q) * 64'(RecB);
            assign p5      = 64'(s4_q0_reg[n]) * 64'(DivB);

            always_comb
            begin
                s1_next   = src;
                s1_next.q = ARG_W'(p1 >> 30);

                rem3      = s2_p2_reg[n] - p3[30:0];
                c3        = (rem3 >= 31'(DivA)) ? s2_q0_reg[n] + 31'd1 : s2_q0_reg[n];
                s3_next   = s2_reg[n];
                s3_next.q = s2_reg[n].q - ARG_W'(c3);

                rem5        = {1'b0, s4_reg[n].q} - p5[30:0];
                d5          = (rem5 >= 31'(DivB)) ? s4_q0_reg[n] + 31'd1 : s4_q0_reg[n];
                s5_next     = s4_reg[n];
                s5_next.sum = s4_reg[n].sum + d5;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v1_reg[n] <= 1'b0;
                    v2_reg[n] <= 1'b0;
                    v3_reg[n] <= 1'b0;
                    v4_reg[n] <= 1'b0;
                    v5_reg[n] <= 1'b0;
                end
                else if (en)
                begin
                    v1_reg[n] <= src_valid;
                    v2_reg[n] <= v1_reg[n];
                    v3_reg[n] <= v2_reg[n];
                    v4_reg[n] <= v3_reg[n];
                    v5_reg[n] <= v4_reg[n];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    s1_reg[n]    <= s1_next;
                    s2_reg[n]    <= s1_reg[n];
                    s2_p2_reg[n] <= p2_next;
                    s2_q0_reg[n] <= 31'(p2m >> 31);
                    s3_reg[n]    <= s3_next;
                    s4_reg[n]    <= s3_reg[n];
                    s4_q0_reg[n] <= 31'(p4 >> 31);
                    s5_reg[n]    <= s5_next;
                end
            end
        end
    endgenerate

    assign out_valid  = v5_reg[ASIN_TERMS];
    assign angle      = s5_reg[ASIN_TERMS].sum;
    assign angle_flag = s5_reg[ASIN_TERMS].flag;

endmodule

[design/haversine_distance_core.sv]
// ----------------------------------------------------------------------------
// haversine_distance_core
// Throughput: one point pair per cycle while the output buffer is not full,
// set by the fully pipelined cosine and asin(sqrt()) units (no stage is
// reused).
// Reset: rst_n clears all valid bits and the output buffer; no result is
// pending after reset and the block accepts input in the first cycle.
// ----------------------------------------------------------------------------
module haversine_distance_core
    import hvd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pair_valid,
    output logic                     pair_stall,
    input  logic signed [LAT_W-1:0]  lat_a,
    input  logic signed [LON_W-1:0]  lon_a,
    input  logic signed [LAT_W-1:0]  lat_b,
    input  logic signed [LON_W-1:0]  lon_b,
    output logic                     dist_valid,
    input  logic                     dist_stall,
    output logic [DIST_W-1:0]        distance_km
);

    // Signed working width for clamped angles and their differences, and
    // unsigned width of a degree magnitude of up to 360 degrees.
    localparam int AW = (ANGLE_FRAC_BITS + 10 > 30) ? ANGLE_FRAC_BITS + 10 : 30;
    localparam int DW = ANGLE_FRAC_BITS + 9;
    localparam logic signed [AW-1:0] LAT_LIM = AW'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] LON_LIM = AW'(64'd180 << ANGLE_FRAC_BITS);

    function automatic logic signed [AW-1:0] clamp_abs(input logic signed [AW-1:0] v,
                                                       input logic signed [AW-1:0] lim);
        if (v > lim)
            return lim;
        else if (v < -lim)
            return -lim;
        else
            return v;
    endfunction

    function automatic logic [DW-1:0] abs_deg(input logic signed [AW-1:0] v);
        return (v < 0) ? DW'(-v) : DW'(v);
    endfunction

    // The whole pipeline advances together. It holds only while the
    // two-entry output buffer is full, so a finished result waiting on a
    // stalled consumer never blocks the next input transfer by itself.
    logic [1:0] fifo_cnt_reg, fifo_cnt_next;
    logic       en;

    assign en         = (fifo_cnt_reg != 2'd2);
    assign pair_stall = ~en;

    // Stage 1: clamp latitudes to +-90 and longitudes to +-180 degrees.
    logic signed [AW-1:0] s1_lat_a_reg, s1_lon_a_reg, s1_lat_b_reg, s1_lon_b_reg;
    logic                 s1_valid_reg;

    // Stage 2: absolute angle differences and absolute latitudes. A longitude
    // difference beyond 180 degrees is folded inside the cosine unit.
    logic [DW-1:0] s2_dlat_reg, s2_dlon_reg, s2_alat_a_reg, s2_alat_b_reg;
    logic          s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pair_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_lat_a_reg  <= clamp_abs(AW'(lat_a), LAT_LIM);
            s1_lon_a_reg  <= clamp_abs(AW'(lon_a), LON_LIM);
            s1_lat_b_reg  <= clamp_abs(AW'(lat_b), LAT_LIM);
            s1_lon_b_reg  <= clamp_abs(AW'(lon_b), LON_LIM);
            s2_dlat_reg   <= abs_deg(s1_lat_b_reg - s1_lat_a_reg);
            s2_dlon_reg   <= abs_deg(s1_lon_b_reg - s1_lon_a_reg);
            s2_alat_a_reg <= abs_deg(s1_lat_a_reg);
            s2_alat_b_reg <= abs_deg(s1_lat_b_reg);
        end
    end

    // Four cosine units run side by side; they share one valid sequence, so
    // the valid output of the first one stands for all four.
    logic signed [COS_W-1:0] cos_dlat, cos_dlon, cos_lat_a, cos_lat_b;
    logic                    cos_valid;

    hvd_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cos_dlat (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_valid_reg),
        .deg(s2_dlat_reg), .out_valid(cos_valid), .cos_val(cos_dlat)
    );

    hvd_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cos_dlon (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_valid_reg),
        .deg(s2_dlon_reg), .out_valid(), .cos_val(cos_dlon)
    );

    hvd_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cos_lat_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_valid_reg),
        .deg(s2_alat_a_reg), .out_valid(), .cos_val(cos_lat_a)
    );

    hvd_cos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cos_lat_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_valid_reg),
        .deg(s2_alat_b_reg), .out_valid(), .cos_val(cos_lat_b)
    );

    // Stage 3: hav(x) = (1 - cos x) / 2. Latitude cosines are never negative.
    logic signed [33:0] hav_lat_tmp, hav_lon_tmp;
    logic [HAV_W-1:0]   s3_hlat_reg, s3_hlon_reg, s3_ca_reg, s3_cb_reg;
    logic               s3_valid_reg;

    assign hav_lat_tmp = signed'(34'(ONE_Q30)) - 34'(cos_dlat);
    assign hav_lon_tmp = signed'(34'(ONE_Q30)) - 34'(cos_dlon);

    // Stages 4 and 5: hav(dlon) * cos(lat_a) * cos(lat_b), one multiply each.
    logic [63:0]      s4_prod, s5_prod;
    logic [HAV_W-1:0] s4_p1_reg, s4_hlat_reg, s4_cb_reg;
    logic [HAV_W-1:0] s5_p2_reg, s5_hlat_reg;
    logic             s4_valid_reg, s5_valid_reg;

    assign s4_prod = 64'(s3_hlon_reg) * 64'(s3_ca_reg);
    assign s5_prod = 64'(s4_p1_reg) * 64'(s4_cb_reg);

    // Stage 6: a = sum clamped to 1. Above one half, the complement is used
    // and the angle is later taken from pi/2.
    logic [31:0]      a_sum;
    logic [30:0]      a_clamped;
    logic             fold_next;
    logic [ARG_W-1:0] arg_next;
    logic [ARG_W-1:0] s6_arg_reg;
    logic             s6_flag_reg, s6_valid_reg;

    always_comb
    begin
        a_sum     = 32'(s5_hlat_reg) + 32'(s5_p2_reg);
        a_clamped = (a_sum > 32'(ONE_Q30)) ? ONE_Q30 : a_sum[30:0];
        fold_next = (a_clamped > HALF_Q30);
        arg_next  = fold_next ? ARG_W'(ONE_Q30 - a_clamped) : a_clamped[ARG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= cos_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_hlat_reg <= hav_lat_tmp[31:1];
            s3_hlon_reg <= hav_lon_tmp[31:1];
            s3_ca_reg   <= cos_lat_a[HAV_W-1:0];
            s3_cb_reg   <= cos_lat_b[HAV_W-1:0];
            s4_p1_reg   <= HAV_W'(s4_prod >> 30);
            s4_hlat_reg <= s3_hlat_reg;
            s4_cb_reg   <= s3_cb_reg;
            s5_p2_reg   <= HAV_W'(s5_prod >> 30);
            s5_hlat_reg <= s4_hlat_reg;
            s6_arg_reg  <= arg_next;
            s6_flag_reg <= fold_next;
        end
    end

    // Central angle / 2 by asin(sqrt(a)).
    logic [ANG_W-1:0] asin_angle;
    logic             asin_flag, asin_valid;

    hvd_asin u_asin (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s6_valid_reg),
        .arg(s6_arg_reg), .arg_flag(s6_flag_reg), .out_valid(asin_valid),
        .angle(asin_angle), .angle_flag(asin_flag)
    );

    // Stage 7: undo the fold. Stage 8: scale by 2 * R * 256.
    logic [ANG_W-1:0] s7_angle_reg;
    logic             s7_valid_reg;
    logic [52:0]      s8_prod_reg;
    logic             s8_valid_reg;
    logic [63:0]      scale_prod;

    assign scale_prod = 64'(s7_angle_reg) * 64'(DIST_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s7_valid_reg <= asin_valid;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_angle_reg <= asin_flag ? HALF_PI_Q30 - asin_angle : asin_angle;
            s8_prod_reg  <= scale_prod[52:0];
        end
    end

    // Round to nearest with ties up, then saturate to the largest distance.
    logic [53:0]       dist_rnd;
    logic [23:0]       dist_raw;
    logic [DIST_W-1:0] dist_next;

    always_comb
    begin
        dist_rnd  = 54'(s8_prod_reg) + 54'(HALF_Q30);
        dist_raw  = dist_rnd[53:30];
        dist_next = (dist_raw > 24'(DIST_MAX)) ? DIST_MAX : dist_raw[DIST_W-1:0];
    end

    // Two-entry output buffer: head entry drives the output port.
    logic [DIST_W-1:0] fifo_e0_reg, fifo_e1_reg;
    logic              push, pop;

    assign push       = s8_valid_reg && en;
    assign dist_valid = (fifo_cnt_reg != 2'd0);
    assign pop        = dist_valid && !dist_stall;
    assign distance_km = fifo_e0_reg;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (push && !pop)
            fifo_cnt_next = fifo_cnt_reg + 2'd1;
        else if (pop && !push)
            fifo_cnt_next = fifo_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fifo_cnt_reg <= 2'd0;
        else
            fifo_cnt_reg <= fifo_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (push && ((fifo_cnt_reg == 2'd0) || ((fifo_cnt_reg == 2'd1) && pop)))
            fifo_e0_reg <= dist_next;
        else if (pop)
            fifo_e0_reg <= fifo_e1_reg;
        if (push && (fifo_cnt_reg == 2'd1) && !pop)
            fifo_e1_reg <= dist_next;
    end

    // The output buffer never holds more than two results.
    assert property (@(posedge clk) disable iff (!rst_n) fifo_cnt_reg <= 2'd2)
        else $error("output buffer count out of range");

    // A delivered distance never exceeds the saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
                     dist_valid |-> (distance_km <= DIST_MAX))
        else $error("distance above saturation limit");

    // While input is stalled the pipeline is frozen and its last stage holds.
    assert property (@(posedge clk) disable iff (!rst_n)
                     pair_stall |=> $stable(s8_valid_reg))
        else $error("pipeline moved while stalled");

endmodule
